// ===== hdl/pto_pkg.sv =====
package pto_pkg;

  localparam int DEF_ENTITY_COUNT = 64;
  localparam int DEF_COORD_BITS   = 32;

  localparam int OPCODE_W  = 2;
  localparam int ENTITY_W  = 6;
  localparam int COORD_W   = 32;
  localparam int EXTENT_W  = 31;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  localparam logic [OPCODE_W-1:0] OP_SAMPLE    = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_END_FRAME = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_DISABLE   = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_ENABLE    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SHAPE_KIND = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_X   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Y   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Z   = 3'd6;

  localparam logic EV_ENTER = 1'b0;
  localparam logic EV_EXIT  = 1'b1;

  localparam logic SHAPE_SPHERE = 1'b0;
  localparam logic SHAPE_BOX    = 1'b1;

  // Occupancy word layout: previous frame bit and current frame bit.
  localparam int OCC_W    = 2;
  localparam int OCC_PREV = 1;
  localparam int OCC_CUR  = 0;

  typedef struct packed {
    logic                shape_kind;
    logic [COORD_W-1:0]  center_x;
    logic [COORD_W-1:0]  center_y;
    logic [COORD_W-1:0]  center_z;
    logic [EXTENT_W-1:0] extent_x;
    logic [EXTENT_W-1:0] extent_y;
    logic [EXTENT_W-1:0] extent_z;
  } pto_cfg_t;

  typedef struct packed {
    logic done;
    logic enclosed;
  } pto_hit_t;

endpackage

// ===== hdl/pto_intf.sv =====
interface pto_in_if;
  import pto_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic [ENTITY_W-1:0]        entity_index;
  logic signed [COORD_W-1:0]  pos_x;
  logic signed [COORD_W-1:0]  pos_y;
  logic signed [COORD_W-1:0]  pos_z;
  modport source (output valid, opcode, entity_index, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, opcode, entity_index, pos_x, pos_y, pos_z, output ready);
endinterface

interface pto_out_if;
  import pto_pkg::*;
  logic                valid;
  logic                ready;
  logic                event_kind;
  logic [ENTITY_W-1:0] event_entity;
  logic                last_event;
  modport source (output valid, event_kind, event_entity, last_event, input ready);
  modport sink (input valid, event_kind, event_entity, last_event, output ready);
endinterface

interface pto_cfg_if;
  import pto_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/pto_ram.sv =====
module pto_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/pto_geom.sv =====
module pto_geom #(
  parameter int COORD_BITS = pto_pkg::DEF_COORD_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [pto_pkg::COORD_W-1:0] pos_x,
  input  logic signed [pto_pkg::COORD_W-1:0] pos_y,
  input  logic signed [pto_pkg::COORD_W-1:0] pos_z,
  input  pto_pkg::pto_cfg_t                  cfg,
  output pto_pkg::pto_hit_t                  hit
);
  import pto_pkg::*;

  localparam int C = COORD_BITS;

  // Stage 1: absolute differences.
  logic signed [C:0] dx, dy, dz;
  logic [C-1:0]      ax_nxt, ay_nxt, az_nxt;
  logic [C-1:0]      ax_r, ay_r, az_r;
  logic              v1_r;

  // Stage 2: squares and box compare.
  logic [C-2:0]      ex, ey, ez;
  logic [2*C-1:0]    sx_nxt, sy_nxt, sz_nxt;
  logic [2*C-3:0]    rr_nxt;
  logic              box_nxt;
  logic [2*C-1:0]    sx_r, sy_r, sz_r;
  logic [2*C-3:0]    rr_r;
  logic              box_r;
  logic              v2_r;

  // Stage 3: partial sum.
  logic [2*C:0]      sxy_nxt;
  logic [2*C:0]      sxy_r;
  logic [2*C-1:0]    sz3_r;
  logic [2*C-3:0]    rr3_r;
  logic              box3_r;
  logic              v3_r;

  // Stage 4: final sum and compare.
  logic [2*C+1:0]    total;
  logic              enclosed_nxt;
  logic              enclosed_r;
  logic              v4_r;

  assign dx = $signed({pos_x[C-1], pos_x[C-1:0]}) -
              $signed({cfg.center_x[C-1], cfg.center_x[C-1:0]});
  assign dy = $signed({pos_y[C-1], pos_y[C-1:0]}) -
              $signed({cfg.center_y[C-1], cfg.center_y[C-1:0]});
  assign dz = $signed({pos_z[C-1], pos_z[C-1:0]}) -
              $signed({cfg.center_z[C-1], cfg.center_z[C-1:0]});

  // The difference of two C-bit values never reaches 2^C in magnitude.
  assign ax_nxt = dx[C] ? C'(-dx) : C'(dx);
  assign ay_nxt = dy[C] ? C'(-dy) : C'(dy);
  assign az_nxt = dz[C] ? C'(-dz) : C'(dz);

  assign ex = cfg.extent_x[C-2:0];
  assign ey = cfg.extent_y[C-2:0];
  assign ez = cfg.extent_z[C-2:0];

  assign sx_nxt  = ax_r * ax_r;
  assign sy_nxt  = ay_r * ay_r;
  assign sz_nxt  = az_r * az_r;
  assign rr_nxt  = ex * ex;
  assign box_nxt = (ax_r <= {1'b0, ex}) && (ay_r <= {1'b0, ey}) && (az_r <= {1'b0, ez});

  assign sxy_nxt = {1'b0, sx_r} + {1'b0, sy_r};

  assign total        = {1'b0, sxy_r} + {2'b00, sz3_r};
  assign enclosed_nxt = (cfg.shape_kind == SHAPE_BOX) ? box3_r :
                        (total <= {4'b0000, rr3_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    ax_r       <= ax_nxt;
    ay_r       <= ay_nxt;
    az_r       <= az_nxt;
    sx_r       <= sx_nxt;
    sy_r       <= sy_nxt;
    sz_r       <= sz_nxt;
    rr_r       <= rr_nxt;
    box_r      <= box_nxt;
    sxy_r      <= sxy_nxt;
    sz3_r      <= sz_r;
    rr3_r      <= rr_r;
    box3_r     <= box_r;
    enclosed_r <= enclosed_nxt;
  end

  assign hit.done     = v4_r;
  assign hit.enclosed = enclosed_r;

endmodule

// ===== hdl/proximity_trigger_occupancy_unit.sv =====
// Position sample: the enter event follows the 4-stage geometry pipeline (one stage of wide
// squares) and the occupancy memory read-modify-write.
// End of frame and disable walk one occupancy entry per cycle while the result side does not stall.
// Enable and ignored requests complete without leaving idle. One request at a time.
// Reset: configuration registers go to zero, the volume is enabled, and a clearing pass over
// every entry empties the occupancy memory while no request is taken.
module proximity_trigger_occupancy_unit #(
  parameter int ENTITY_COUNT = pto_pkg::DEF_ENTITY_COUNT,
  parameter int COORD_BITS   = pto_pkg::DEF_COORD_BITS
) (
  input logic        clk,
  input logic        rst_n,
  pto_in_if.sink     in_chan,
  pto_out_if.source  out_chan,
  pto_cfg_if.sink    cfg_chan
);
  import pto_pkg::*;

  localparam int AW = (ENTITY_COUNT > 1) ? $clog2(ENTITY_COUNT) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(ENTITY_COUNT - 1);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SAMPLE = 3'd2;
  localparam logic [2:0] ST_WALK   = 3'd3;
  localparam logic [2:0] ST_FLUSH  = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;
  logic [AW-1:0]       ent_r, ent_nxt;
  logic                enabled_r, enabled_nxt;
  logic                walk_dis_r, walk_dis_nxt;
  logic                pend_v_r, pend_v_nxt;
  logic                pend_kind_r, pend_kind_nxt;
  logic [AW-1:0]       pend_ent_r, pend_ent_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_kind_r, out_kind_nxt;
  logic [ENTITY_W-1:0] out_ent_r, out_ent_nxt;
  logic                out_last_r, out_last_nxt;
  pto_cfg_t            cfg_r;

  logic                in_acc;
  logic                in_ok;
  logic                out_free;
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [OCC_W-1:0]    ram_wdata, ram_rdata;
  logic                occ_prev, occ_cur;
  logic                walk_ev;
  logic                geo_start;
  pto_hit_t            hit;

  pto_ram #(
    .WIDTH (OCC_W),
    .DEPTH (ENTITY_COUNT)
  ) u_occ_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pto_geom #(
    .COORD_BITS (COORD_BITS)
  ) u_geom (
    .clk   (clk),
    .rst_n (rst_n),
    .start (geo_start),
    .pos_x (in_chan.pos_x),
    .pos_y (in_chan.pos_y),
    .pos_z (in_chan.pos_z),
    .cfg   (cfg_r),
    .hit   (hit)
  );

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid & in_chan.ready;
  assign in_ok         = {1'b0, in_chan.entity_index} < (ENTITY_W + 1)'(ENTITY_COUNT);
  assign out_free      = !out_valid_r || out_chan.ready;
  assign occ_prev      = ram_rdata[OCC_PREV];
  assign occ_cur       = ram_rdata[OCC_CUR];
  assign walk_ev       = walk_dis_r ? (occ_prev | occ_cur) : (occ_prev & ~occ_cur);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    ent_nxt       = ent_r;
    enabled_nxt   = enabled_r;
    walk_dis_nxt  = walk_dis_r;
    pend_v_nxt    = pend_v_r;
    pend_kind_nxt = pend_kind_r;
    pend_ent_nxt  = pend_ent_r;
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_ent_nxt   = out_ent_r;
    out_last_nxt  = out_last_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = idx_r;
    geo_start     = 1'b0;

    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        ram_we  = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_chan.opcode)
            OP_SAMPLE: begin
              if (enabled_r && in_ok) begin
                ram_re    = 1'b1;
                ram_raddr = in_chan.entity_index[AW-1:0];
                ent_nxt   = in_chan.entity_index[AW-1:0];
                geo_start = 1'b1;
                state_nxt = ST_SAMPLE;
              end
            end
            OP_END_FRAME: begin
              if (enabled_r) begin
                ram_re       = 1'b1;
                ram_raddr    = '0;
                idx_nxt      = '0;
                walk_dis_nxt = 1'b0;
                state_nxt    = ST_WALK;
              end
            end
            OP_DISABLE: begin
              ram_re       = 1'b1;
              ram_raddr    = '0;
              idx_nxt      = '0;
              walk_dis_nxt = 1'b1;
              enabled_nxt  = 1'b0;
              state_nxt    = ST_WALK;
            end
            OP_ENABLE: begin
              enabled_nxt = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SAMPLE: begin
        // The occupancy read issued at acceptance is held until the test completes.
        if (hit.done) begin
          if (hit.enclosed && !occ_cur) begin
            ram_we             = 1'b1;
            ram_waddr          = ent_r;
            ram_wdata          = ram_rdata;
            ram_wdata[OCC_CUR] = 1'b1;
            if (!occ_prev) begin
              pend_v_nxt    = 1'b1;
              pend_kind_nxt = EV_ENTER;
              pend_ent_nxt  = ent_r;
            end
          end
          state_nxt = ST_FLUSH;
        end
      end
      ST_WALK: begin
        // One event is held back so the final one can be flagged as last.
        if (!(walk_ev && pend_v_r && !out_free)) begin
          ram_we    = 1'b1;
          ram_waddr = idx_r;
          if (!walk_dis_r) begin
            ram_wdata[OCC_PREV] = occ_cur;
          end
          if (walk_ev) begin
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = pend_kind_r;
              out_ent_nxt   = ENTITY_W'(pend_ent_r);
              out_last_nxt  = 1'b0;
            end
            pend_v_nxt    = 1'b1;
            pend_kind_nxt = EV_EXIT;
            pend_ent_nxt  = idx_r;
          end
          if (idx_r == LAST_IDX) begin
            state_nxt = ST_FLUSH;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_r + 1'b1;
            idx_nxt   = idx_r + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (pend_v_r) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = pend_kind_r;
            out_ent_nxt   = ENTITY_W'(pend_ent_r);
            out_last_nxt  = 1'b1;
            pend_v_nxt    = 1'b0;
            state_nxt     = ST_IDLE;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      idx_r       <= '0;
      enabled_r   <= 1'b1;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      enabled_r   <= enabled_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r       <= ent_nxt;
    walk_dis_r  <= walk_dis_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_ent_r  <= pend_ent_nxt;
    out_kind_r  <= out_kind_nxt;
    out_ent_r   <= out_ent_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      unique case (cfg_chan.index)
        REG_SHAPE_KIND: cfg_r.shape_kind <= cfg_chan.data[0];
        REG_CENTER_X:   cfg_r.center_x   <= cfg_chan.data[COORD_W-1:0];
        REG_CENTER_Y:   cfg_r.center_y   <= cfg_chan.data[COORD_W-1:0];
        REG_CENTER_Z:   cfg_r.center_z   <= cfg_chan.data[COORD_W-1:0];
        REG_EXTENT_X:   cfg_r.extent_x   <= cfg_chan.data[EXTENT_W-1:0];
        REG_EXTENT_Y:   cfg_r.extent_y   <= cfg_chan.data[EXTENT_W-1:0];
        REG_EXTENT_Z:   cfg_r.extent_z   <= cfg_chan.data[EXTENT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.event_kind   = out_kind_r;
  assign out_chan.event_entity = out_ent_r;
  assign out_chan.last_event   = out_last_r;

endmodule
